/* rtl/ps2hlc_pkg.sv */
package ps2hlc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int DATA_BITS       = 8;
   localparam int FRAME_BITS      = 11;
   localparam int BIT_INDEX_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEND_IDLE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INHIBIT       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATA_LEAD     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOCK_RELEASE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECEIVE_SETTLE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_DELAY  = 3'd5;

   localparam logic [CSR_DATA_WIDTH-1:0] SEND_IDLE_RESET      = 16'd200;
   localparam logic [CSR_DATA_WIDTH-1:0] INHIBIT_RESET        = 16'd150;
   localparam logic [CSR_DATA_WIDTH-1:0] DATA_LEAD_RESET      = 16'd10;
   localparam logic [CSR_DATA_WIDTH-1:0] CLOCK_RELEASE_RESET  = 16'd5;
   localparam logic [CSR_DATA_WIDTH-1:0] RECEIVE_SETTLE_RESET = 16'd50;
   localparam logic [CSR_DATA_WIDTH-1:0] SAMPLE_DELAY_RESET   = 16'd5;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_SEND    = 2'd1;
   localparam logic [1:0] OP_RECEIVE = 2'd2;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] send_idle_ticks;
      logic [CSR_DATA_WIDTH-1:0] inhibit_ticks;
      logic [CSR_DATA_WIDTH-1:0] data_lead_ticks;
      logic [CSR_DATA_WIDTH-1:0] clock_release_ticks;
      logic [CSR_DATA_WIDTH-1:0] receive_settle_ticks;
      logic [CSR_DATA_WIDTH-1:0] sample_delay_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [DATA_BITS-1:0] tx_byte;
      logic                 clk_line;
      logic                 dat_line;
   } req_data_type;

   typedef struct packed {
      logic                 clk_drive_low;
      logic                 dat_drive_low;
      logic                 rx_valid;
      logic [DATA_BITS-1:0] rx_byte;
      logic                 tx_done;
      logic                 busy_res;
   } rsp_data_type;

endpackage

/* rtl/ps2hlc_req_if.sv */
interface ps2hlc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] tx_byte;
   logic       clk_line;
   logic       dat_line;

   modport source (output valid, output op, output tx_byte, output clk_line,
                   output dat_line, input ready);
   modport sink (input valid, input op, input tx_byte, input clk_line,
                 input dat_line, output ready);
endinterface

/* rtl/ps2hlc_rsp_if.sv */
interface ps2hlc_rsp_if;
   logic       valid;
   logic       ready;
   logic       clk_drive_low;
   logic       dat_drive_low;
   logic       rx_valid;
   logic [7:0] rx_byte;
   logic       tx_done;
   logic       busy_res;

   modport source (output valid, output clk_drive_low, output dat_drive_low,
                   output rx_valid, output rx_byte, output tx_done, output busy_res,
                   input ready);
   modport sink (input valid, input clk_drive_low, input dat_drive_low,
                 input rx_valid, input rx_byte, input tx_done, input busy_res,
                 output ready);
endinterface

/* rtl/ps2hlc_csr.sv */
module ps2hlc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [ps2hlc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ps2hlc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output ps2hlc_pkg::cfg_type                    cfg
);

   ps2hlc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.send_idle_ticks      <= ps2hlc_pkg::SEND_IDLE_RESET;
         cfg_ff.inhibit_ticks        <= ps2hlc_pkg::INHIBIT_RESET;
         cfg_ff.data_lead_ticks      <= ps2hlc_pkg::DATA_LEAD_RESET;
         cfg_ff.clock_release_ticks  <= ps2hlc_pkg::CLOCK_RELEASE_RESET;
         cfg_ff.receive_settle_ticks <= ps2hlc_pkg::RECEIVE_SETTLE_RESET;
         cfg_ff.sample_delay_ticks   <= ps2hlc_pkg::SAMPLE_DELAY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ps2hlc_pkg::CSR_SEND_IDLE:      cfg_ff.send_idle_ticks      <= csr_wdata;
            ps2hlc_pkg::CSR_INHIBIT:        cfg_ff.inhibit_ticks        <= csr_wdata;
            ps2hlc_pkg::CSR_DATA_LEAD:      cfg_ff.data_lead_ticks      <= csr_wdata;
            ps2hlc_pkg::CSR_CLOCK_RELEASE:  cfg_ff.clock_release_ticks  <= csr_wdata;
            ps2hlc_pkg::CSR_RECEIVE_SETTLE: cfg_ff.receive_settle_ticks <= csr_wdata;
            ps2hlc_pkg::CSR_SAMPLE_DELAY:   cfg_ff.sample_delay_ticks   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/ps2hlc_seq.sv */
module ps2hlc_seq #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  ps2hlc_pkg::req_data_type item,
   input  ps2hlc_pkg::cfg_type      cfg,
   output ps2hlc_pkg::rsp_data_type result
);

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_TX_RELEASE,
      PH_TX_INHIBIT,
      PH_TX_LEAD,
      PH_TX_CLKREL,
      PH_TX_FIRST,
      PH_TX_RISE,
      PH_TX_FALL,
      PH_TX_POST,
      PH_TX_ACK_DLO,
      PH_TX_ACK_CLO,
      PH_TX_ACK_DHI,
      PH_TX_ACK_CHI,
      PH_RX_SETTLE,
      PH_RX_FALL,
      PH_RX_DELAY,
      PH_RX_RISE
   } phase_type;

   phase_type                                 phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]                    timer_ff, timer_in;
   logic [ps2hlc_pkg::BIT_INDEX_WIDTH-1:0]    bit_index_ff, bit_index_in;
   logic [ps2hlc_pkg::FRAME_BITS-1:0]         frame_ff, frame_in;
   logic                                      parity_ff, parity_in;
   logic                                      clk_hold_ff, clk_hold_in;
   logic                                      dat_hold_ff, dat_hold_in;
   logic [ps2hlc_pkg::BIT_INDEX_WIDTH-1:0]    next_index;
   logic                                      tx_bit;
   logic                                      timer_zero;
   logic                                      rx_valid;
   logic [ps2hlc_pkg::DATA_BITS-1:0]          rx_byte;
   logic                                      tx_done;

   function automatic logic [TIMER_WIDTH-1:0] load_value(
      input logic [ps2hlc_pkg::CSR_DATA_WIDTH-1:0] v);
      logic [31:0] wide;
      wide = {16'b0, v};
      return wide[TIMER_WIDTH-1:0];
   endfunction

   assign timer_zero = (timer_ff == '0);
   assign next_index = bit_index_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      bit_index_in = bit_index_ff;
      frame_in     = frame_ff;
      parity_in    = parity_ff;
      clk_hold_in  = clk_hold_ff;
      dat_hold_in  = dat_hold_ff;
      rx_valid     = 1'b0;
      rx_byte      = '0;
      tx_done      = 1'b0;
      tx_bit       = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (item.op == ps2hlc_pkg::OP_SEND) begin
                  clk_hold_in  = 1'b0;
                  dat_hold_in  = 1'b0;
                  frame_in     = {3'b0, item.tx_byte};
                  parity_in    = 1'b1;
                  bit_index_in = '0;
                  timer_in     = load_value(cfg.send_idle_ticks);
                  phase_in     = PH_TX_RELEASE;
               end else if (item.op == ps2hlc_pkg::OP_RECEIVE) begin
                  clk_hold_in  = 1'b0;
                  dat_hold_in  = 1'b0;
                  frame_in     = '0;
                  bit_index_in = '0;
                  timer_in     = load_value(cfg.receive_settle_ticks);
                  phase_in     = PH_RX_SETTLE;
               end
            end
            PH_TX_RELEASE: begin
               if (timer_zero) begin
                  clk_hold_in = 1'b1;
                  timer_in    = load_value(cfg.inhibit_ticks);
                  phase_in    = PH_TX_INHIBIT;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            PH_TX_INHIBIT: begin
               if (timer_zero) begin
                  dat_hold_in = 1'b1;
                  timer_in    = load_value(cfg.data_lead_ticks);
                  phase_in    = PH_TX_LEAD;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            PH_TX_LEAD: begin
               if (timer_zero) begin
                  clk_hold_in = 1'b0;
                  timer_in    = load_value(cfg.clock_release_ticks);
                  phase_in    = PH_TX_CLKREL;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            PH_TX_CLKREL: begin
               if (timer_zero) begin
                  phase_in = PH_TX_FIRST;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            PH_TX_FIRST: begin
               if (!item.clk_line) begin
                  tx_bit       = frame_ff[0];
                  parity_in    = parity_ff ^ tx_bit;
                  dat_hold_in  = !tx_bit;
                  bit_index_in = '0;
                  phase_in     = PH_TX_RISE;
               end
            end
            PH_TX_RISE: begin
               if (item.clk_line) phase_in = PH_TX_FALL;
            end
            PH_TX_FALL: begin
               if (!item.clk_line) begin
                  bit_index_in = next_index;
                  if (next_index < 4'd8) begin
                     tx_bit      = frame_ff[next_index[2:0]];
                     parity_in   = parity_ff ^ tx_bit;
                     dat_hold_in = !tx_bit;
                     phase_in    = PH_TX_RISE;
                  end else if (next_index == 4'd8) begin
                     tx_bit      = parity_ff;
                     dat_hold_in = !tx_bit;
                     phase_in    = PH_TX_RISE;
                  end else begin
                     dat_hold_in = 1'b0;
                     timer_in    = load_value(cfg.data_lead_ticks);
                     phase_in    = PH_TX_POST;
                  end
               end
            end
            PH_TX_POST: begin
               if (timer_zero) begin
                  phase_in = PH_TX_ACK_DLO;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            PH_TX_ACK_DLO: begin
               if (!item.dat_line) phase_in = PH_TX_ACK_CLO;
            end
            PH_TX_ACK_CLO: begin
               if (!item.clk_line) phase_in = PH_TX_ACK_DHI;
            end
            PH_TX_ACK_DHI: begin
               if (item.dat_line) phase_in = PH_TX_ACK_CHI;
            end
            PH_TX_ACK_CHI: begin
               if (item.clk_line) begin
                  dat_hold_in = 1'b1;
                  tx_done     = 1'b1;
                  phase_in    = PH_IDLE;
               end
            end
            PH_RX_SETTLE: begin
               if (timer_zero) begin
                  phase_in = PH_RX_FALL;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            PH_RX_FALL: begin
               if (!item.clk_line) begin
                  timer_in = load_value(cfg.sample_delay_ticks);
                  phase_in = PH_RX_DELAY;
               end
            end
            PH_RX_DELAY: begin
               if (timer_zero) begin
                  if (item.dat_line && bit_index_ff < 4'd11) begin
                     frame_in = frame_ff | (11'd1 << bit_index_ff);
                  end
                  phase_in = PH_RX_RISE;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
            PH_RX_RISE: begin
               if (item.clk_line) begin
                  bit_index_in = next_index;
                  if (next_index >= 4'd11) begin
                     clk_hold_in = 1'b1;
                     rx_valid    = 1'b1;
                     rx_byte     = frame_ff[8:1];
                     phase_in    = PH_IDLE;
                  end else begin
                     phase_in = PH_RX_FALL;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         bit_index_ff <= '0;
         frame_ff     <= '0;
         parity_ff    <= 1'b1;
         clk_hold_ff  <= 1'b0;
         dat_hold_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         bit_index_ff <= bit_index_in;
         frame_ff     <= frame_in;
         parity_ff    <= parity_in;
         clk_hold_ff  <= clk_hold_in;
         dat_hold_ff  <= dat_hold_in;
      end
   end

   assign result.clk_drive_low = clk_hold_in;
   assign result.dat_drive_low = dat_hold_in;
   assign result.rx_valid      = rx_valid;
   assign result.rx_byte       = rx_byte;
   assign result.tx_done       = tx_done;
   assign result.busy_res      = (phase_in != PH_IDLE);

`ifndef NO_ASSERTIONS
   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(timer_ff) && $stable(frame_ff))
      else $error("state moved without a request");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      step && (result.tx_done || result.rx_valid) |=> phase_ff == PH_IDLE)
      else $error("completion did not return to idle");

   a_receive_releases_clock: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RX_SETTLE || phase_ff == PH_RX_FALL ||
       phase_ff == PH_RX_DELAY || phase_ff == PH_RX_RISE) |-> !clk_hold_ff)
      else $error("clock held low during receive");

   a_timer_counts_down: assert property (@(posedge clock) disable iff (reset)
      step && !timer_zero &&
      (phase_ff == PH_TX_RELEASE || phase_ff == PH_TX_INHIBIT ||
       phase_ff == PH_TX_LEAD || phase_ff == PH_TX_CLKREL ||
       phase_ff == PH_TX_POST || phase_ff == PH_RX_SETTLE ||
       phase_ff == PH_RX_DELAY)
      |=> timer_ff == $past(timer_ff) - 1'b1 && phase_ff == $past(phase_ff))
      else $error("timed wait did not count down");

   a_bit_index_bound: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_TX_RISE |-> bit_index_ff <= 4'd8)
      else $error("send bit index out of range");
`endif

endmodule

/* rtl/ps2_host_line_controller.sv */
// PS/2 host line controller. Each request is one time tick carrying the sampled
// clock and data lines and an optional send or receive start; each request
// yields exactly one response with the line drives and status after that tick.
// One request is taken per clock cycle unless stalled; a request passes the input
// register, then the sequencer step into the response register. Requests keep
// flowing while a response waits, stalling only when both registers are full.
// Timed phases count TIMER_WIDTH-bit tick counters loaded from the csr_ registers,
// which must be written by the user only while the block is idle (not enforced).
module ps2_host_line_controller #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   ps2hlc_req_if.sink                             req_if,
   ps2hlc_rsp_if.source                           rsp_if,
   input  logic                                   csr_write_en,
   input  logic [ps2hlc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ps2hlc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   ps2hlc_pkg::cfg_type      cfg;
   ps2hlc_pkg::req_data_type item_ff;
   ps2hlc_pkg::rsp_data_type rsp_ff;
   ps2hlc_pkg::rsp_data_type result;
   logic                     item_valid_ff;
   logic                     rsp_valid_ff;
   logic                     step;
   logic                     req_take;

   assign step     = item_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !item_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            item_valid_ff <= 1'b1;
         end else if (step) begin
            item_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.op       <= req_if.op;
         item_ff.tx_byte  <= req_if.tx_byte;
         item_ff.clk_line <= req_if.clk_line;
         item_ff.dat_line <= req_if.dat_line;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   ps2hlc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ps2hlc_seq #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.clk_drive_low = rsp_ff.clk_drive_low;
   assign rsp_if.dat_drive_low = rsp_ff.dat_drive_low;
   assign rsp_if.rx_valid      = rsp_ff.rx_valid;
   assign rsp_if.rx_byte       = rsp_ff.rx_byte;
   assign rsp_if.tx_done       = rsp_ff.tx_done;
   assign rsp_if.busy_res      = rsp_ff.busy_res;

endmodule

/* verif/ps2hlc_line_checker.sv */
`timescale 1ns / 1ps
module ps2hlc_line_checker
   import ps2hlc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   ps2hlc_req_if                      req_mon,
   ps2hlc_rsp_if                      rsp_mon,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_TX_RELEASE,
      PH_TX_INHIBIT,
      PH_TX_LEAD,
      PH_TX_CLKREL,
      PH_TX_FIRST,
      PH_TX_RISE,
      PH_TX_FALL,
      PH_TX_POST,
      PH_TX_ACK_DLO,
      PH_TX_ACK_CLO,
      PH_TX_ACK_DHI,
      PH_TX_ACK_CHI,
      PH_RX_SETTLE,
      PH_RX_FALL,
      PH_RX_DELAY,
      PH_RX_RISE
   } line_phase_type;

   cfg_type                    cfg;
   line_phase_type             phase;
   logic [CSR_DATA_WIDTH-1:0]  tick_left;
   logic [BIT_INDEX_WIDTH-1:0] bit_pos;
   logic [FRAME_BITS-1:0]      frame;
   logic                       parity;
   logic                       clk_low;
   logic                       dat_low;
   rsp_data_type               line_status_q[$];
   rsp_data_type               got;
   rsp_data_type               want;
   req_data_type               tick_in;
   int                         rsp_num;

   function automatic logic timer_expired();
      if (tick_left == '0) return 1'b1;
      tick_left = tick_left - 1'b1;
      return 1'b0;
   endfunction

   task automatic set_tx_bit();
      logic b;
      if (bit_pos < DATA_BITS) begin
         b = frame[bit_pos];
         parity = parity ^ b;
      end else begin
         b = parity;
      end
      dat_low = ~b;
   endtask

   task automatic step_line(input req_data_type t, output rsp_data_type s);
      s = '0;
      case (phase)
         PH_IDLE: begin
            if (t.op == OP_SEND) begin
               clk_low   = 1'b0;
               dat_low   = 1'b0;
               frame     = {{(FRAME_BITS - DATA_BITS){1'b0}}, t.tx_byte};
               parity    = 1'b1;
               bit_pos   = '0;
               tick_left = cfg.send_idle_ticks;
               phase     = PH_TX_RELEASE;
            end else if (t.op == OP_RECEIVE) begin
               clk_low   = 1'b0;
               dat_low   = 1'b0;
               frame     = '0;
               bit_pos   = '0;
               tick_left = cfg.receive_settle_ticks;
               phase     = PH_RX_SETTLE;
            end
         end
         PH_TX_RELEASE: begin
            if (timer_expired()) begin
               clk_low   = 1'b1;
               tick_left = cfg.inhibit_ticks;
               phase     = PH_TX_INHIBIT;
            end
         end
         PH_TX_INHIBIT: begin
            if (timer_expired()) begin
               dat_low   = 1'b1;
               tick_left = cfg.data_lead_ticks;
               phase     = PH_TX_LEAD;
            end
         end
         PH_TX_LEAD: begin
            if (timer_expired()) begin
               clk_low   = 1'b0;
               tick_left = cfg.clock_release_ticks;
               phase     = PH_TX_CLKREL;
            end
         end
         PH_TX_CLKREL: begin
            if (timer_expired()) phase = PH_TX_FIRST;
         end
         PH_TX_FIRST: begin
            if (!t.clk_line) begin
               bit_pos = '0;
               set_tx_bit();
               phase = PH_TX_RISE;
            end
         end
         PH_TX_RISE: begin
            if (t.clk_line) phase = PH_TX_FALL;
         end
         PH_TX_FALL: begin
            if (!t.clk_line) begin
               bit_pos = bit_pos + 1'b1;
               if (bit_pos <= DATA_BITS) begin
                  set_tx_bit();
                  phase = PH_TX_RISE;
               end else begin
                  dat_low   = 1'b0;
                  tick_left = cfg.data_lead_ticks;
                  phase     = PH_TX_POST;
               end
            end
         end
         PH_TX_POST: begin
            if (timer_expired()) phase = PH_TX_ACK_DLO;
         end
         PH_TX_ACK_DLO: begin
            if (!t.dat_line) phase = PH_TX_ACK_CLO;
         end
         PH_TX_ACK_CLO: begin
            if (!t.clk_line) phase = PH_TX_ACK_DHI;
         end
         PH_TX_ACK_DHI: begin
            if (t.dat_line) phase = PH_TX_ACK_CHI;
         end
         PH_TX_ACK_CHI: begin
            if (t.clk_line) begin
               dat_low   = 1'b1;
               s.tx_done = 1'b1;
               phase     = PH_IDLE;
            end
         end
         PH_RX_SETTLE: begin
            if (timer_expired()) phase = PH_RX_FALL;
         end
         PH_RX_FALL: begin
            if (!t.clk_line) begin
               tick_left = cfg.sample_delay_ticks;
               phase     = PH_RX_DELAY;
            end
         end
         PH_RX_DELAY: begin
            if (timer_expired()) begin
               if (t.dat_line && bit_pos < FRAME_BITS) frame[bit_pos] = 1'b1;
               phase = PH_RX_RISE;
            end
         end
         PH_RX_RISE: begin
            if (t.clk_line) begin
               bit_pos = bit_pos + 1'b1;
               if (bit_pos >= FRAME_BITS) begin
                  clk_low    = 1'b1;
                  s.rx_valid = 1'b1;
                  s.rx_byte  = frame[DATA_BITS:1];
                  phase      = PH_IDLE;
               end else begin
                  phase = PH_RX_FALL;
               end
            end
         end
         default: phase = PH_IDLE;
      endcase
      s.clk_drive_low = clk_low;
      s.dat_drive_low = dat_low;
      s.busy_res      = (phase != PH_IDLE);
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t: response %0d: %s", $realtime, rsp_num, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.send_idle_ticks      = SEND_IDLE_RESET;
         cfg.inhibit_ticks        = INHIBIT_RESET;
         cfg.data_lead_ticks      = DATA_LEAD_RESET;
         cfg.clock_release_ticks  = CLOCK_RELEASE_RESET;
         cfg.receive_settle_ticks = RECEIVE_SETTLE_RESET;
         cfg.sample_delay_ticks   = SAMPLE_DELAY_RESET;
         phase      = PH_IDLE;
         tick_left  = '0;
         bit_pos    = '0;
         frame      = '0;
         parity     = 1'b1;
         clk_low    = 1'b0;
         dat_low    = 1'b0;
         fail_count = 0;
         rsp_num    = 0;
         line_status_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SEND_IDLE:      cfg.send_idle_ticks      = csr_wdata;
               CSR_INHIBIT:        cfg.inhibit_ticks        = csr_wdata;
               CSR_DATA_LEAD:      cfg.data_lead_ticks      = csr_wdata;
               CSR_CLOCK_RELEASE:  cfg.clock_release_ticks  = csr_wdata;
               CSR_RECEIVE_SETTLE: cfg.receive_settle_ticks = csr_wdata;
               CSR_SAMPLE_DELAY:   cfg.sample_delay_ticks   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.clk_drive_low = rsp_mon.clk_drive_low;
            got.dat_drive_low = rsp_mon.dat_drive_low;
            got.rx_valid      = rsp_mon.rx_valid;
            got.rx_byte       = rsp_mon.rx_byte;
            got.tx_done       = rsp_mon.tx_done;
            got.busy_res      = rsp_mon.busy_res;
            if (line_status_q.size() == 0) begin
               report_mismatch("response with no request pending");
            end else begin
               want = line_status_q.pop_front();
               if (got.clk_drive_low !== want.clk_drive_low)
                  report_mismatch($sformatf("clk_drive_low is %0b, expected %0b",
                                            got.clk_drive_low, want.clk_drive_low));
               if (got.dat_drive_low !== want.dat_drive_low)
                  report_mismatch($sformatf("dat_drive_low is %0b, expected %0b",
                                            got.dat_drive_low, want.dat_drive_low));
               if (got.rx_valid !== want.rx_valid)
                  report_mismatch($sformatf("rx_valid is %0b, expected %0b",
                                            got.rx_valid, want.rx_valid));
               if (got.rx_byte !== want.rx_byte)
                  report_mismatch($sformatf("rx_byte is %02h, expected %02h",
                                            got.rx_byte, want.rx_byte));
               if (got.tx_done !== want.tx_done)
                  report_mismatch($sformatf("tx_done is %0b, expected %0b",
                                            got.tx_done, want.tx_done));
               if (got.busy_res !== want.busy_res)
                  report_mismatch($sformatf("busy_res is %0b, expected %0b",
                                            got.busy_res, want.busy_res));
            end
            rsp_num++;
         end
         if (req_mon.valid && req_mon.ready) begin
            tick_in.op       = req_mon.op;
            tick_in.tx_byte  = req_mon.tx_byte;
            tick_in.clk_line = req_mon.clk_line;
            tick_in.dat_line = req_mon.dat_line;
            step_line(tick_in, want);
            line_status_q.push_back(want);
         end
      end
      pending = line_status_q.size();
   end

endmodule

/* verif/tb_ps2_host_line_controller.sv */
`timescale 1ns / 1ps
module tb_ps2_host_line_controller;
   import ps2hlc_pkg::*;

   typedef enum {DAT_RANDOM, DAT_ZEROS, DAT_ONES} dat_mode_type;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 400;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAST_LAST = CSR_SAMPLE_DELAY + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOP_INDEX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int   fail_count;
   int   pending;
   int   rsp_seen = 0;
   int   stall_cycles = 0;
   bit   quiet = 1'b0;
   logic dev_clk = 1'b1;
   int   half_left = 0;
   int   half_max = 2;

   ps2hlc_req_if req_bus ();
   ps2hlc_rsp_if rsp_bus ();

   ps2_host_line_controller u_top (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_bus),
      .rsp_if       (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   ps2hlc_line_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) rsp_seen++;
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_ps2_host_line_controller: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int  held_for;
      bit  held;
      held = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= HOLD_AFTER) begin
            held = 1'b1;
            held_for = 0;
            rsp_bus.ready <= 1'b0;
            while (held_for < HOLD_CYCLES) begin
               @(negedge clock);
               held_for++;
            end
         end
         rsp_bus.ready <= quiet || ($urandom_range(99) >= 19);
      end
   end

   task automatic put_request(input logic [1:0] op, input logic [DATA_BITS-1:0] txb,
                              input logic clk, input logic dat);
      while (!quiet && $urandom_range(99) < 19) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.tx_byte  <= txb;
      req_bus.clk_line <= clk;
      req_bus.dat_line <= dat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Device side: free-running line clock, data per mode, stray starts now and then.
   task automatic device_ticks(input int n, input dat_mode_type mode);
      int         i;
      logic [1:0] op;
      logic       d;
      for (i = 0; i < n; i++) begin
         if (half_left == 0) begin
            dev_clk = ~dev_clk;
            half_left = $urandom_range(half_max, 1);
         end
         half_left--;
         case (mode)
            DAT_ZEROS: d = 1'b0;
            DAT_ONES:  d = 1'b1;
            default:   d = 1'($urandom_range(1));
         endcase
         op = ($urandom_range(99) < 3) ? 2'($urandom_range(3)) : OP_TICK;
         put_request(op, 8'($urandom_range(255)), dev_clk, d);
      end
   endtask

   task automatic noise_ticks(input int n);
      int i;
      for (i = 0; i < n; i++)
         put_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic transfer(input logic [1:0] op, input logic [DATA_BITS-1:0] txb,
                           input int n, input dat_mode_type mode);
      half_max = $urandom_range(3, 1);
      put_request(op, txb, dev_clk, 1'b1);
      device_ticks(n, mode);
   endtask

   task automatic random_mix(input int n);
      int done;
      int len;
      int pick;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(99);
         len  = $urandom_range(120, 60);
         if (pick < 40) begin
            transfer(OP_SEND, 8'($urandom_range(255)), len, DAT_RANDOM);
         end else if (pick < 75) begin
            transfer(OP_RECEIVE, '0, len, dat_mode_type'($urandom_range(2)));
         end else begin
            len = $urandom_range(30, 5);
            noise_ticks(len);
         end
         done += len + 1;
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(CSR_SEND_IDLE,      c.send_idle_ticks);
      write_reg(CSR_INHIBIT,        c.inhibit_ticks);
      write_reg(CSR_DATA_LEAD,      c.data_lead_ticks);
      write_reg(CSR_CLOCK_RELEASE,  c.clock_release_ticks);
      write_reg(CSR_RECEIVE_SETTLE, c.receive_settle_ticks);
      write_reg(CSR_SAMPLE_DELAY,   c.sample_delay_ticks);
      // unmapped indexes must not alias a register
      write_reg(CSR_PAST_LAST, 16'($urandom));
      write_reg(CSR_TOP_INDEX, 16'($urandom));
      csr_write_en <= 1'b0;
   endtask

   function automatic cfg_type random_config(input int hi);
      cfg_type c;
      c.send_idle_ticks      = 16'($urandom_range(hi));
      c.inhibit_ticks        = 16'($urandom_range(hi));
      c.data_lead_ticks      = 16'($urandom_range(hi));
      c.clock_release_ticks  = 16'($urandom_range(hi));
      c.receive_settle_ticks = 16'($urandom_range(hi));
      c.sample_delay_ticks   = 16'($urandom_range(hi));
      return c;
   endfunction

   initial begin
      cfg_type c;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_TICK;
      req_bus.tx_byte  = '0;
      req_bus.clk_line = 1'b1;
      req_bus.dat_line = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle ticks on every line level, unused op, then a receive at reset timing
      put_request(OP_TICK, 8'h00, 1'b0, 1'b0);
      put_request(OP_TICK, 8'hFF, 1'b1, 1'b1);
      put_request(OP_SPARE, 8'h5A, 1'b0, 1'b1);
      put_request(OP_TICK, 8'hA5, 1'b1, 1'b0);
      transfer(OP_RECEIVE, 8'hFF, 200, DAT_ONES);
      drain_results();

      c = '0;
      load_config(c);
      transfer(OP_SEND, 8'hFF, 60, DAT_RANDOM);
      transfer(OP_RECEIVE, 8'h00, 50, DAT_ZEROS);
      transfer(OP_SEND, 8'hA5, 60, DAT_RANDOM);
      random_mix(40);
      drain_results();

      load_config(random_config(3));
      random_mix(40);
      drain_results();

      // no idling on either side
      load_config(random_config(2));
      quiet = 1'b1;
      random_mix(40);
      drain_results();
      quiet = 1'b0;

      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("tb_ps2_host_line_controller: PASS");
      else
         $display("tb_ps2_host_line_controller: FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/ps2hlc_pkg.sv
rtl/ps2hlc_req_if.sv
rtl/ps2hlc_rsp_if.sv
rtl/ps2hlc_csr.sv
rtl/ps2hlc_seq.sv
rtl/ps2_host_line_controller.sv
verif/ps2hlc_line_checker.sv
verif/tb_ps2_host_line_controller.sv
